FILE: rtl/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg: shared types and constants for the numeric literal parser
// Character codes, parse phase and radix codes, and the per-literal state
// record that moves between the absorb, finish and top-level logic.
// ----------------------------------------------------------------------------
package nlp_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int ACC_W           = 64;
	localparam int DBITS_W         = 7;
	localparam int CHAR_W          = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'd49;  // '1'
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;  // '9'
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;  // '-'
	localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'd120; // 'x'
	localparam logic [CHAR_W-1:0] CHAR_LC_B  = 8'd98;  // 'b'
	localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'd65;  // 'A'
	localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'd70;  // 'F'

	localparam logic [DBITS_W-1:0] DIGIT_BITS_CAP = 7'd64;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_ZERO   = 3'd1,
		PH_DEC    = 3'd2,
		PH_MINUS  = 3'd3,
		PH_PREFIX = 3'd4,
		PH_RDIG   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		RM_DEC = 2'd0,
		RM_BIN = 2'd1,
		RM_HEX = 2'd2
	} radix_t;

	typedef struct packed {
		phase_t              phase;
		radix_t              radix;
		logic                negative;
		logic [ACC_W-1:0]    acc;
		logic [DBITS_W-1:0]  digit_bits;
		logic                ovf;
		logic                invalid;
		logic                lead;
	} lit_state_t;

	localparam lit_state_t LIT_RESET = '{
		phase:      PH_START,
		radix:      RM_DEC,
		negative:   1'b0,
		acc:        '0,
		digit_bits: '0,
		ovf:        1'b0,
		invalid:    1'b0,
		lead:       1'b0
	};

endpackage

FILE: rtl/nlp_absorb.sv
// ----------------------------------------------------------------------------
// nlp_absorb: per-character state update
// Folds one character into the literal state: prefix detection, decimal
// multiply-add with overflow flag, and binary/hex shift-in.
// ----------------------------------------------------------------------------
module nlp_absorb
	import nlp_pkg::*;
(
	input  logic [CHAR_W-1:0] char_code,
	input  lit_state_t        cur,
	output lit_state_t        nxt
);

	logic                 is_dig;
	logic [3:0]           dec_val;
	logic [ACC_W+3:0]     dec_sum;
	logic                 rd_ok;
	logic [3:0]           rd_val;
	logic                 is_bin;
	logic [ACC_W-1:0]     rd_acc;
	logic [DBITS_W:0]     db_sum;
	logic [DBITS_W-1:0]   db_next;

	always_comb begin
		is_dig  = char_code inside {[CHAR_ZERO:CHAR_NINE]};
		dec_val = char_code[3:0];
		// acc*10 + d as (acc<<3) + (acc<<1) + d, four guard bits catch overflow
		dec_sum = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1)
			+ {{(ACC_W){1'b0}}, dec_val};

		is_bin = (cur.radix == RM_BIN);
		if (is_bin) begin
			rd_ok  = (char_code == CHAR_ZERO) || (char_code == CHAR_ONE);
			rd_val = {3'b000, char_code[0]};
		end else if (is_dig) begin
			rd_ok  = 1'b1;
			rd_val = char_code[3:0];
		end else if (char_code inside {[CHAR_UC_A:CHAR_UC_F]}) begin
			rd_ok  = 1'b1;
			rd_val = char_code[3:0] + 4'd9;
		end else begin
			rd_ok  = 1'b0;
			rd_val = 4'd0;
		end
		rd_acc = is_bin ? {cur.acc[ACC_W-2:0], rd_val[0]} : {cur.acc[ACC_W-5:0], rd_val};
		db_sum = {1'b0, cur.digit_bits} + (is_bin ? 8'd1 : 8'd4);
		db_next = (db_sum > {1'b0, DIGIT_BITS_CAP}) ? DIGIT_BITS_CAP : db_sum[DBITS_W-1:0];

		nxt = cur;
		if (!cur.invalid) begin
			case (cur.phase)
				PH_START: begin
					if (char_code == CHAR_ZERO) begin
						nxt.phase = PH_ZERO;
					end else if (is_dig) begin
						nxt.acc   = dec_sum[ACC_W-1:0];
						nxt.ovf   = cur.ovf | (|dec_sum[ACC_W+3:ACC_W]);
						nxt.phase = PH_DEC;
					end else if (char_code == CHAR_MINUS) begin
						nxt.negative = 1'b1;
						nxt.phase    = PH_MINUS;
					end else begin
						nxt.invalid = 1'b1;
					end
				end
				PH_ZERO: begin
					if (char_code == CHAR_LC_B) begin
						nxt.radix = RM_BIN;
						nxt.phase = PH_PREFIX;
					end else if (char_code == CHAR_LC_X) begin
						nxt.radix = RM_HEX;
						nxt.phase = PH_PREFIX;
					end else if (is_dig) begin
						nxt.acc   = dec_sum[ACC_W-1:0];
						nxt.ovf   = cur.ovf | (|dec_sum[ACC_W+3:ACC_W]);
						nxt.phase = PH_DEC;
					end else begin
						nxt.invalid = 1'b1;
					end
				end
				PH_MINUS, PH_DEC: begin
					if (is_dig) begin
						nxt.acc   = dec_sum[ACC_W-1:0];
						nxt.ovf   = cur.ovf | (|dec_sum[ACC_W+3:ACC_W]);
						nxt.phase = PH_DEC;
					end else begin
						nxt.invalid = 1'b1;
					end
				end
				PH_PREFIX, PH_RDIG: begin
					if (!rd_ok) begin
						nxt.invalid = 1'b1;
					end else begin
						// remember the sign bit of the first digit
						if (cur.phase == PH_PREFIX)
							nxt.lead = is_bin ? rd_val[0] : rd_val[3];
						nxt.acc        = rd_acc;
						nxt.digit_bits = db_next;
						nxt.phase      = PH_RDIG;
					end
				end
				default: begin
					nxt.invalid = 1'b1;
				end
			endcase
		end
	end

endmodule

FILE: rtl/nlp_finish.sv
// ----------------------------------------------------------------------------
// nlp_finish: literal completion
// Turns the final literal state into the result pattern: sign extension for
// binary/hex, saturation and negation for decimal, and the error flag.
// ----------------------------------------------------------------------------
module nlp_finish
	import nlp_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  lit_state_t       lit,
	input  logic             signed_mode,
	output logic [ACC_W-1:0] value,
	output logic             error
);

	localparam logic [ACC_W-1:0] MASK =
		(VALUE_WIDTH >= ACC_W) ? {ACC_W{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
	localparam logic [ACC_W-1:0] HALF = 64'd1 << (VALUE_WIDTH - 1);
	localparam logic [DBITS_W-1:0] VW_BITS = DBITS_W'(VALUE_WIDTH);

	logic [ACC_W-1:0] ext;
	logic             big_neg;
	logic             big_pos;
	logic             big_uns;

	always_comb begin
		ext     = {ACC_W{1'b1}} << lit.digit_bits;
		big_neg = lit.ovf || (lit.acc > HALF);
		big_pos = lit.ovf || (lit.acc > (HALF - 64'd1));
		big_uns = lit.ovf || (lit.acc > MASK);
		value   = '0;
		error   = 1'b0;

		if (lit.invalid) begin
			error = 1'b1;
		end else if (lit.phase == PH_RDIG) begin
			if (signed_mode && lit.lead && (lit.digit_bits < VW_BITS))
				value = (lit.acc | ext) & MASK;
			else
				value = lit.acc & MASK;
		end else if (lit.phase != PH_ZERO && lit.phase != PH_DEC) begin
			// lone minus or bare prefix: no digits
			error = 1'b1;
		end else if (lit.negative) begin
			if (!signed_mode)
				error = 1'b1;
			else if (big_neg)
				value = (64'd0 - HALF) & MASK;
			else
				value = (64'd0 - lit.acc) & MASK;
		end else if (signed_mode) begin
			value = big_pos ? (HALF - 64'd1) : lit.acc;
		end else begin
			value = big_uns ? MASK : lit.acc;
		end
	end

endmodule

FILE: rtl/numeric_literal_parser_unit.sv
// ----------------------------------------------------------------------------
// numeric_literal_parser_unit: streaming integer literal parser
// Reads ASCII literals one character per beat and returns one value/error
// beat per literal, at the beat marked last.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+----------------------------------------------------------
//  s_*      | in  | tdata[7:0] = char_code, tlast = last_char
//  m_*      | out | tdata[63:0] = value, tuser[0] = error
//  cfg_*    | in  | data[0] = signed_mode (reset 1), always ready
//
//  One character beat per cycle, sustained, back to back across literals,
//  while no result is held back by m_tready. A result passes the input
//  register, the state update and the finish stage into the output register.
//  Stalls on m_tready back up through the finish stage to s_tready; beats
//  without tlast keep flowing while a result waits.
//  Reset clears the literal state and sets signed_mode.
// ----------------------------------------------------------------------------
module numeric_literal_parser_unit
	import nlp_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_code
	input  logic              s_tlast,   // last_char
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ACC_W-1:0]  m_tdata,   // [63:0] value
	output logic [0:0]        m_tuser,   // [0] error
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_data   // [0] signed_mode
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	lit_state_t        lit_q;
	lit_state_t        lit_nxt;
	logic              signed_q;

	logic              valid_s2;
	lit_state_t        lit_s2;
	logic              signed_s2;

	logic              out_valid_q;
	logic [ACC_W-1:0]  value_q;
	logic              error_q;

	logic [ACC_W-1:0]  fin_value;
	logic              fin_error;

	logic              out_free;
	logic              s2_free;
	logic              s1_adv;

	assign out_free  = !out_valid_q || m_tready;
	assign s2_free   = !valid_s2 || out_free;
	assign s1_adv    = valid_s1 && (!last_s1 || s2_free);
	assign s_tready  = !valid_s1 || s1_adv;
	assign cfg_ready = 1'b1;

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = value_q;
	assign m_tuser[0] = error_q;

	nlp_absorb u_absorb (
		.char_code (char_s1),
		.cur       (lit_q),
		.nxt       (lit_nxt)
	);

	nlp_finish #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_finish (
		.lit         (lit_s2),
		.signed_mode (signed_s2),
		.value       (fin_value),
		.error       (fin_error)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			signed_q <= cfg_data[0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// literal state: restart after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= LIT_RESET;
		end else if (s1_adv) begin
			lit_q <= last_s1 ? LIT_RESET : lit_nxt;
		end
	end

	// finished literal, waiting for the finish stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			lit_s2    <= lit_nxt;
			signed_s2 <= signed_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			value_q <= fin_value;
			error_q <= fin_error;
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("error beat carries a nonzero value");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> VALUE_WIDTH) == '0)
		else $error("value has bits above VALUE_WIDTH");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> lit_q.phase == PH_START && !lit_q.invalid
			&& lit_q.acc == '0)
		else $error("literal state not cleared after last beat");

	a_dbits: assert property (@(posedge clk) disable iff (!arst_n)
		lit_q.digit_bits <= DIGIT_BITS_CAP)
		else $error("digit count past cap");

endmodule

FILE: tb/sv/numeric_literal_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// numeric_literal_parser_unit_tb: self-checking bench for the literal parser
// Streams decimal, binary and hex literals, malformed ones and raw byte
// noise into the parser in signed and unsigned mode. A local model of the
// parse predicts value and error for every beat marked last, and each result
// beat is checked against the oldest prediction. Both stream sides stall at
// random, including one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module numeric_literal_parser_unit_tb;
	import nlp_pkg::*;

	localparam int          DRAIN_CYCLES      = 8;
	localparam int          LONG_HOLD_CYCLES  = 300;
	localparam int          MAX_REPORTS       = 40;
	localparam logic [63:0] SIGN_BIT          = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES          = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [7:0]  LOWER_CASE_OFFSET = 8'd32;

	typedef byte unsigned char_q_t[$];

	typedef struct {
		logic [63:0] value;
		logic        err;
	} parse_result_t;

	typedef enum int unsigned {
		KIND_DEC,
		KIND_BIN,
		KIND_HEX,
		KIND_EDGE,
		KIND_BROKEN,
		KIND_NOISE
	} lit_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_data;

	// parser model state, one literal in flight
	phase_t      lit_phase;
	radix_t      lit_radix;
	logic        lit_neg;
	logic [63:0] lit_acc;
	int unsigned lit_bits;
	logic        lit_ovf;
	logic        lit_bad;
	logic        lit_lead;
	logic        mode_signed;

	parse_result_t expected_values[$];
	parse_result_t checked_want;

	int unsigned chars_sent;
	int unsigned results_seen;
	int unsigned error_count;
	bit          quiet_tail;
	bit          long_hold_req;

	numeric_literal_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] char_code
		.s_tlast   (s_tlast),   // last_char
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [63:0] value
		.m_tuser   (m_tuser),   // [0] error
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)   // [0] signed_mode
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void clear_literal();
		lit_phase = PH_START;
		lit_radix = RM_DEC;
		lit_neg   = 1'b0;
		lit_acc   = '0;
		lit_bits  = 0;
		lit_ovf   = 1'b0;
		lit_bad   = 1'b0;
		lit_lead  = 1'b0;
	endfunction

	function automatic void decimal_step(int unsigned d);
		if (lit_acc > (ALL_ONES - 64'(d)) / 64'd10)
			lit_ovf = 1'b1;
		lit_acc = lit_acc * 64'd10 + 64'(d);
	endfunction

	// Advance the model by one character; on the last one queue the result.
	function automatic void parse_char(logic [7:0] c, logic last);
		logic          is_dig;
		int            dv;
		int unsigned   step;
		logic [63:0]   v;
		parse_result_t r;
		is_dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
		if (!lit_bad) begin
			case (lit_phase)
				PH_START: begin
					if (c == CHAR_ZERO) begin
						lit_phase = PH_ZERO;
					end else if (is_dig) begin
						decimal_step(int'(c - CHAR_ZERO));
						lit_phase = PH_DEC;
					end else if (c == CHAR_MINUS) begin
						lit_neg   = 1'b1;
						lit_phase = PH_MINUS;
					end else begin
						lit_bad = 1'b1;
					end
				end
				PH_ZERO: begin
					if (c == CHAR_LC_B) begin
						lit_radix = RM_BIN;
						lit_phase = PH_PREFIX;
					end else if (c == CHAR_LC_X) begin
						lit_radix = RM_HEX;
						lit_phase = PH_PREFIX;
					end else if (is_dig) begin
						decimal_step(int'(c - CHAR_ZERO));
						lit_phase = PH_DEC;
					end else begin
						lit_bad = 1'b1;
					end
				end
				PH_MINUS, PH_DEC: begin
					if (is_dig) begin
						decimal_step(int'(c - CHAR_ZERO));
						lit_phase = PH_DEC;
					end else begin
						lit_bad = 1'b1;
					end
				end
				PH_PREFIX, PH_RDIG: begin
					if (lit_radix == RM_BIN) begin
						dv   = (c == CHAR_ZERO) ? 0 : (c == CHAR_ONE) ? 1 : -1;
						step = 1;
					end else begin
						if (is_dig)
							dv = int'(c - CHAR_ZERO);
						else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
							dv = int'(c - CHAR_UC_A) + 10;
						else
							dv = -1;
						step = 4;
					end
					if (dv < 0) begin
						lit_bad = 1'b1;
					end else begin
						if (lit_phase == PH_PREFIX)
							lit_lead = (lit_radix == RM_BIN) ? dv[0] : dv[3];
						lit_acc   = (lit_acc << step) | 64'(dv);
						lit_bits  = (lit_bits + step > 64) ? 64 : lit_bits + step;
						lit_phase = PH_RDIG;
					end
				end
				default: lit_bad = 1'b1;
			endcase
		end
		if (last) begin
			r.value = '0;
			r.err   = 1'b1;
			if (!lit_bad) begin
				if (lit_phase == PH_RDIG) begin
					v = lit_acc;
					// sign-extend only while the digits cover fewer than 64 bits
					if (mode_signed && lit_lead && lit_bits < 64)
						v = v | (ALL_ONES << lit_bits);
					r.value = v;
					r.err   = 1'b0;
				end else if (lit_phase == PH_ZERO || lit_phase == PH_DEC) begin
					if (lit_neg) begin
						if (mode_signed) begin
							r.err   = 1'b0;
							r.value = (lit_ovf || lit_acc > SIGN_BIT) ? SIGN_BIT
								: 64'd0 - lit_acc;
						end
					end else if (mode_signed) begin
						r.err   = 1'b0;
						r.value = (lit_ovf || lit_acc > SIGN_BIT - 1) ? SIGN_BIT - 1 : lit_acc;
					end else begin
						r.err   = 1'b0;
						r.value = lit_ovf ? ALL_ONES : lit_acc;
					end
				end
			end
			expected_values.push_back(r);
			clear_literal();
		end
	endfunction

	function automatic char_q_t to_chars(string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic char_q_t make_literal(lit_kind_t kind);
		char_q_t     lit;
		int unsigned n;
		int unsigned d;
		string       edges[5];
		edges = '{"9223372036854775807", "9223372036854775808", "18446744073709551615",
			"18446744073709551616", "99999999999999999999"};
		case (kind)
			KIND_DEC: begin
				if ($urandom_range(0, 3) == 0)
					lit.push_back(CHAR_MINUS);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 8);
				repeat (n) lit.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
			KIND_BIN: begin
				lit = '{CHAR_ZERO, CHAR_LC_B};
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 16);
				repeat (n) lit.push_back(CHAR_ZERO + 8'($urandom_range(0, 1)));
			end
			KIND_HEX: begin
				lit = '{CHAR_ZERO, CHAR_LC_X};
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 6);
				repeat (n) begin
					d = $urandom_range(0, 15);
					lit.push_back((d < 10) ? CHAR_ZERO + 8'(d) : CHAR_UC_A + 8'(d - 10));
				end
			end
			KIND_EDGE: begin
				lit = to_chars(edges[$urandom_range(0, 4)]);
				if ($urandom_range(0, 1) == 1)
					lit.push_front(CHAR_MINUS);
			end
			KIND_BROKEN: begin
				lit = make_literal(lit_kind_t'($urandom_range(KIND_DEC, KIND_HEX)));
				d = $urandom_range(0, lit.size() - 1);
				case ($urandom_range(0, 2))
					0: lit[d] = 8'($urandom_range(0, 255));
					1: lit.insert(d, CHAR_UC_A + LOWER_CASE_OFFSET + 8'($urandom_range(0, 5)));
					default: while (lit.size() > 2) void'(lit.pop_back());
				endcase
			end
			default: begin
				repeat ($urandom_range(1, 5)) lit.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		return lit;
	endfunction

	function automatic lit_kind_t pick_kind();
		int unsigned w;
		w = $urandom_range(0, 19);
		if (w < 6) return KIND_DEC;
		if (w < 10) return KIND_BIN;
		if (w < 14) return KIND_HEX;
		if (w < 16) return KIND_EDGE;
		if (w < 18) return KIND_BROKEN;
		return KIND_NOISE;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("MISMATCH at %0t ns: %s got %h expected %h", $time, what, got, want);
	endtask

	// Call at a falling edge; returns at a falling edge.
	task automatic send_char(logic [7:0] c, logic last);
		s_tdata  <= c;
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		parse_char(c, last);
		chars_sent++;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	task automatic send_literal(char_q_t lit);
		foreach (lit[i])
			send_char(lit[i], i == lit.size() - 1);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_values.size() != 0) @(negedge clk);
		// non-final beats may still be in the pipe
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_signed_mode(logic m);
		wait_idle();
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		mode_signed = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_signed_directed();
		// signed mode straight out of reset
		send_literal(to_chars("0b1"));
		send_literal(to_chars("0"));
		send_literal(to_chars("007"));
		send_literal(to_chars("-0"));
		send_literal(to_chars("-"));
		send_literal(to_chars("0b"));
		send_literal(to_chars("0x"));
		send_literal(to_chars("0b101"));
		send_literal(to_chars("0xFF"));
		send_literal(to_chars("0x7F"));
		send_literal(to_chars("0xa"));
		send_literal(to_chars("0b2"));
		send_literal(to_chars("12a34"));
		send_literal(to_chars("9223372036854775807"));
		send_literal(to_chars("9223372036854775808"));
		send_literal(to_chars("-9223372036854775808"));
		send_literal(to_chars("-99999999999999999999"));
		send_literal(to_chars("0x1FFFFFFFFFFFFFFFF"));
	endtask

	task automatic test_unsigned_directed();
		set_signed_mode(1'b0);
		send_literal(to_chars("-5"));
		send_literal(to_chars("18446744073709551615"));
		send_literal(to_chars("18446744073709551616"));
		send_literal(to_chars("0xFF"));
		send_literal(to_chars("0b1"));
		set_signed_mode(1'b1);
	endtask

	task automatic test_random_literals();
		int unsigned goal;
		for (int p = 0; p < 4; p++) begin
			set_signed_mode(p[0] ^ 1'b1);
			goal = chars_sent + 320;
			while (chars_sent < goal)
				send_literal(make_literal(pick_kind()));
		end
	endtask

	task automatic test_output_stall();
		char_q_t one_digit;
		long_hold_req = 1'b1;
		// short literals pile up results until the input backs up
		repeat (40) begin
			if ($urandom_range(0, 3) == 0) begin
				send_literal(make_literal(pick_kind()));
			end else begin
				one_digit = '{CHAR_ZERO + 8'($urandom_range(0, 9))};
				send_literal(one_digit);
			end
		end
		wait_idle();
		repeat (10) send_literal(make_literal(pick_kind()));
	endtask

	task automatic test_quiet_tail();
		int unsigned goal;
		set_signed_mode(1'($urandom_range(0, 1)));
		quiet_tail = 1'b1;
		goal = chars_sent + 250;
		while (chars_sent < goal)
			send_literal(make_literal(pick_kind()));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				report_mismatch("result beat with none pending", m_tdata, '0);
			end else begin
				checked_want = expected_values.pop_front();
				results_seen++;
				if (m_tdata !== checked_want.value)
					report_mismatch("value", m_tdata, checked_want.value);
				if (m_tuser[0] !== checked_want.err)
					report_mismatch("error flag", 64'(m_tuser), 64'(checked_want.err));
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				for (int hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++)
					@(negedge clk);
				long_hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#6_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		chars_sent    = 0;
		results_seen  = 0;
		error_count   = 0;
		quiet_tail    = 1'b0;
		long_hold_req = 1'b0;
		mode_signed   = 1'b1;
		clear_literal();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_signed_directed();
		test_unsigned_directed();
		test_random_literals();
		test_output_stall();
		test_quiet_tail();

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Checked %0d literal results from %0d characters in both modes,", results_seen,
			chars_sent);
		$display("with random stalls on both sides and one long output hold-off.");
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/nlp_pkg.sv
rtl/nlp_absorb.sv
rtl/nlp_finish.sv
rtl/numeric_literal_parser_unit.sv
tb/sv/numeric_literal_parser_unit_tb.sv
